FILE: rtl/u8svd_pkg.sv
// Package for the UTF-8 sequence validator and decoder.
// Word types, lead-byte and lane result structs, byte range constants.
// No dependencies.
`default_nettype none

package u8svd_pkg;

  localparam int unsigned MaxSeq    = 6;
  localparam int unsigned NumLanes  = MaxSeq - 1;

  localparam logic [7:0] ContLo     = 8'h80;
  localparam logic [7:0] ContHi     = 8'hBF;
  localparam logic [2:0] AvailMax   = 3'd6;

  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [2:0] avail;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  length;
    logic [30:0] code_point;
  } out_t;

  // What the lead byte tells the lanes and the merge stage.
  typedef struct packed {
    logic [2:0] length;     // 0 for an illegal lead
    logic [7:0] second_lo;
    logic [7:0] second_hi;
  } lead_t;

  // One continuation lane: range check and its six payload bits.
  typedef struct packed {
    logic       ok;
    logic [5:0] bits;
  } lane_t;

endpackage

`default_nettype wire

FILE: rtl/utf8_sequence_validate_decode.sv
// Top level of the UTF-8 sequence validator and decoder.
// Depends on u8svd_pkg, u8svd_lead, u8svd_lane and u8svd_merge.
`default_nettype none

// Validates and decodes the first UTF-8 character (legacy five- and six-byte
// forms included) of a six-byte word. The lead byte decoder and five
// continuation lanes work side by side and the merge stage combines them
// into the output register. A result is valid in the cycle after its word is
// accepted; a new word is taken every cycle while the output is free
// or being taken, so throughput is one word per cycle, set by the single
// output register. Illegal characters report ok low with zero length and
// code point. No state is kept between words.
module utf8_sequence_validate_decode
  import u8svd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  lead_t                info;
  lane_t [NumLanes-1:0] lanes;
  out_t                 res;
  logic [7:0]           lane_byte [NumLanes];

  assign lane_byte[0] = in_data.byte_1;
  assign lane_byte[1] = in_data.byte_2;
  assign lane_byte[2] = in_data.byte_3;
  assign lane_byte[3] = in_data.byte_4;
  assign lane_byte[4] = in_data.byte_5;

  u8svd_lead u_lead (
    .lead (in_data.byte_0),
    .info (info)
  );

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    u8svd_lane u_lane (
      .data (lane_byte[k]),
      .lo   ((k == 0) ? info.second_lo : ContLo),
      .hi   ((k == 0) ? info.second_hi : ContHi),
      .res  (lanes[k])
    );
  end

  u8svd_merge u_merge (
    .lead  (in_data.byte_0),
    .avail (in_data.avail),
    .info  (info),
    .lanes (lanes),
    .res   (res)
  );

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= res;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word did not produce a result");

  a_illegal_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |-> out_data.length == 3'd0 && out_data.code_point == '0)
    else $error("illegal result carries length or code point");

  a_legal_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ok |-> out_data.length != 3'd0 && out_data.length <= AvailMax)
    else $error("legal result with bad length");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: rtl/u8svd_lead.sv
// Lead byte decoder: sequence length and second-byte limits.
// Depends on u8svd_pkg.
`default_nettype none

module u8svd_lead
  import u8svd_pkg::*;
(
  input  logic [7:0] lead,
  output lead_t      info
);

  always_comb begin
    info.second_lo = ContLo;
    info.second_hi = ContHi;
    case (lead) inside
      [8'h00:8'h7F]: info.length = 3'd1;
      [8'hC2:8'hDF]: info.length = 3'd2;
      [8'hE0:8'hEF]: info.length = 3'd3;
      [8'hF0:8'hF7]: info.length = 3'd4;
      [8'hF8:8'hFB]: info.length = 3'd5;
      [8'hFC:8'hFD]: info.length = 3'd6;
      default:       info.length = 3'd0;
    endcase
    // tighten the second byte to reject overlong and surrogate forms
    case (lead)
      8'hE0:   info.second_lo = 8'hA0;
      8'hED:   info.second_hi = 8'h9F;
      8'hF0:   info.second_lo = 8'h90;
      8'hF8:   info.second_lo = 8'h88;
      8'hFC:   info.second_lo = 8'h84;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/u8svd_lane.sv
// One continuation byte lane: range check against limits and payload extract.
// Depends on u8svd_pkg.
`default_nettype none

module u8svd_lane
  import u8svd_pkg::*;
(
  input  logic [7:0] data,
  input  logic [7:0] lo,
  input  logic [7:0] hi,
  output lane_t      res
);

  assign res.ok   = (data >= lo) && (data <= hi);
  assign res.bits = data[5:0];

endmodule

`default_nettype wire

FILE: rtl/u8svd_merge.sv
// Merge stage: combines lead info and lane checks into one result word.
// Depends on u8svd_pkg.
`default_nettype none

module u8svd_merge
  import u8svd_pkg::*;
(
  input  logic [7:0]              lead,
  input  logic [2:0]              avail,
  input  lead_t                   info,
  input  lane_t [NumLanes-1:0]    lanes,
  output out_t                    res
);

  logic [2:0]          avail_sat;
  logic [NumLanes-1:0] lane_fail;
  logic                legal;
  logic [30:0]         cp;

  assign avail_sat = (avail > AvailMax) ? AvailMax : avail;

  // a lane counts only when it lies inside the sequence
  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      lane_fail[k] = (info.length > 3'(k + 1)) && !lanes[k].ok;
    end
  end

  assign legal = (info.length != 3'd0) && (info.length <= avail_sat) && (lane_fail == '0);

  always_comb begin
    case (info.length)
      3'd2:    cp = {20'd0, lead[4:0], lanes[0].bits};
      3'd3:    cp = {15'd0, lead[3:0], lanes[0].bits, lanes[1].bits};
      3'd4:    cp = {10'd0, lead[2:0], lanes[0].bits, lanes[1].bits, lanes[2].bits};
      3'd5:    cp = {5'd0, lead[1:0], lanes[0].bits, lanes[1].bits, lanes[2].bits,
                     lanes[3].bits};
      3'd6:    cp = {lead[0], lanes[0].bits, lanes[1].bits, lanes[2].bits,
                     lanes[3].bits, lanes[4].bits};
      default: cp = {24'd0, lead[6:0]};
    endcase
  end

  always_comb begin
    if (lead == 8'h00) begin
      // NUL is a one-byte character even with nothing available
      res.ok         = 1'b1;
      res.length     = 3'd1;
      res.code_point = '0;
    end else if (legal) begin
      res.ok         = 1'b1;
      res.length     = info.length;
      res.code_point = cp;
    end else begin
      res.ok         = 1'b0;
      res.length     = 3'd0;
      res.code_point = '0;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/utf8_decode_checker.sv
// Checker for utf8_sequence_validate_decode: watches both word channels,
// predicts the first character of each accepted word and compares results.
// Depends on u8svd_pkg.
module utf8_decode_checker
  import u8svd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Lead bytes that narrow the range of the second byte
  localparam logic [7:0] LeadE0 = 8'hE0;
  localparam logic [7:0] LeadED = 8'hED;
  localparam logic [7:0] LeadF0 = 8'hF0;
  localparam logic [7:0] LeadF8 = 8'hF8;
  localparam logic [7:0] LeadFC = 8'hFC;

  out_t expected_chars[$];
  out_t want;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic flag_error(input string what);
    $display("%0t ns ERROR: %s", $time, what);
    mismatches++;
  endtask

  function automatic out_t decode_first_char(input in_t w);
    logic [7:0]  b [MaxSeq];
    logic [2:0]  avail;
    logic [2:0]  len;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [31:0] cp;
    logic        legal;
    out_t        r;
    int          i;
    b[0] = w.byte_0;
    b[1] = w.byte_1;
    b[2] = w.byte_2;
    b[3] = w.byte_3;
    b[4] = w.byte_4;
    b[5] = w.byte_5;
    avail = (w.avail > AvailMax) ? AvailMax : w.avail;
    r = '0;
    // a zero byte is always a one-byte character, window or not
    if (b[0] == 8'h00) begin
      r.ok = 1'b1;
      r.length = 3'd1;
      return r;
    end
    if (b[0] < 8'h80) len = 3'd1;
    else if (b[0] < 8'hC2) len = 3'd0;
    else if (b[0] < 8'hE0) len = 3'd2;
    else if (b[0] < 8'hF0) len = 3'd3;
    else if (b[0] < 8'hF8) len = 3'd4;
    else if (b[0] < 8'hFC) len = 3'd5;
    else if (b[0] < 8'hFE) len = 3'd6;
    else len = 3'd0;
    lo = ContLo;
    hi = ContHi;
    case (b[0])
      LeadE0: lo = 8'hA0;
      LeadED: hi = 8'h9F;
      LeadF0: lo = 8'h90;
      LeadF8: lo = 8'h88;
      LeadFC: lo = 8'h84;
      default: ;
    endcase
    legal = (len != 3'd0) && (len <= avail);
    if (legal && len >= 3'd2) begin
      if (b[1] < lo || b[1] > hi) legal = 1'b0;
      for (i = 2; i < len; i++)
        if (b[i] < ContLo || b[i] > ContHi) legal = 1'b0;
    end
    if (!legal) return r;
    if (len == 3'd1) begin
      cp = {24'd0, b[0]};
    end else begin
      cp = {24'd0, b[0]} & ((32'd1 << (7 - len)) - 32'd1);
      for (i = 1; i < len; i++)
        cp = (cp << 6) | {26'd0, b[i][5:0]};
    end
    r.ok = 1'b1;
    r.length = len;
    r.code_point = cp[30:0];
    return r;
  endfunction

  // Retire the result first: a word accepted at this edge cannot be out yet
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          flag_error($sformatf("result ok=%0b len=%0d cp=%h with nothing expected",
                               out_data.ok, out_data.length, out_data.code_point));
        end else begin
          want = expected_chars.pop_front();
          if (out_data.ok !== want.ok)
            flag_error($sformatf("ok %0b, expected %0b", out_data.ok, want.ok));
          if (out_data.length !== want.length)
            flag_error($sformatf("length %0d, expected %0d", out_data.length, want.length));
          if (out_data.code_point !== want.code_point)
            flag_error($sformatf("code point %h, expected %h",
                                 out_data.code_point, want.code_point));
        end
      end
      if (in_valid && in_ready)
        expected_chars.push_back(decode_first_char(in_data));
    end
    pending = expected_chars.size();
  end

endmodule

FILE: tb/sv/utf8_sequence_validate_decode_test.sv
// Testbench top for utf8_sequence_validate_decode: drives directed and random
// byte windows under varying idling and gives the verdict.
// Depends on u8svd_pkg, utf8_decode_checker and the block's RTL.
module utf8_sequence_validate_decode_test;
  timeunit 1ns;
  timeprecision 1ps;
  import u8svd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int StallCycles = 200;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int mismatches;
  int pending;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int holds_done     = 0;
  int words_sent     = 0;
  int well_formed    = 0;
  int broken         = 0;
  int noise          = 0;

  utf8_sequence_validate_decode dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  utf8_decode_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        out_ready <= 1'b0;
        repeat (StallCycles - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Entered and left at a falling edge; valid stays up between back-to-back words
  task automatic send_word(input in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic in_t make_char(input int unsigned len);
    logic [7:0] b [MaxSeq];
    int         i;
    for (i = 0; i < MaxSeq; i++) b[i] = 8'($urandom_range(255));
    for (i = 1; i < len; i++) b[i] = 8'($urandom_range(ContHi, ContLo));
    case (len)
      1: b[0] = 8'($urandom_range(8'h7F, 8'h00));
      2: b[0] = 8'($urandom_range(8'hDF, 8'hC2));
      3: b[0] = $urandom_range(3) == 0 ? ($urandom_range(1) ? 8'hE0 : 8'hED)
                                        : 8'($urandom_range(8'hEF, 8'hE0));
      4: b[0] = $urandom_range(3) == 0 ? 8'hF0 : 8'($urandom_range(8'hF7, 8'hF0));
      5: b[0] = $urandom_range(3) == 0 ? 8'hF8 : 8'($urandom_range(8'hFB, 8'hF8));
      default: b[0] = $urandom_range(3) == 0 ? 8'hFC : 8'($urandom_range(8'hFD, 8'hFC));
    endcase
    // keep the second byte inside the narrowed range
    case (b[0])
      8'hE0: b[1] = 8'($urandom_range(8'hBF, 8'hA0));
      8'hED: b[1] = 8'($urandom_range(8'h9F, 8'h80));
      8'hF0: b[1] = 8'($urandom_range(8'hBF, 8'h90));
      8'hF8: b[1] = 8'($urandom_range(8'hBF, 8'h88));
      8'hFC: b[1] = 8'($urandom_range(8'hBF, 8'h84));
      default: ;
    endcase
    return in_t'{b[0], b[1], b[2], b[3], b[4], b[5], 3'($urandom_range(7, len))};
  endfunction

  function automatic in_t break_char(input in_t w, input int unsigned len);
    logic [7:0] bad;
    int unsigned pick;
    if ($urandom_range(1)) bad = 8'($urandom_range(8'h7F, 8'h00));
    else bad = 8'($urandom_range(8'hFF, 8'hC0));
    pick = (len == 1) ? 0 : $urandom_range(2);
    case (pick)
      0: w.avail = 3'($urandom_range(len - 1, 0));
      1: begin
        case ($urandom_range(len - 1, 1))
          1: w.byte_1 = bad;
          2: w.byte_2 = bad;
          3: w.byte_3 = bad;
          4: w.byte_4 = bad;
          default: w.byte_5 = bad;
        endcase
      end
      // any continuation value as second byte: illegal only after a narrowing lead
      default: w.byte_1 = 8'($urandom_range(ContHi, ContLo));
    endcase
    return w;
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    in_t         w;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      len  = $urandom_range(MaxSeq, 1);
      w    = make_char(len);
      if (kind < 70) begin
        well_formed++;
      end else if (kind < 85) begin
        w = break_char(w, len);
        broken++;
      end else begin
        w = in_t'({$urandom, $urandom});
        noise++;
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero lead and 7F lead, with and without a window
    send_word(in_t'{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0});
    send_word(in_t'{8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd7});
    send_word(in_t'{8'h7F, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 3'd1});
    send_word(in_t'{8'h7F, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd0});
    // illegal leads
    send_word(in_t'{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6});
    send_word(in_t'{8'hC1, 8'hBF, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6});
    send_word(in_t'{8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6});
    send_word(in_t'{8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7});
    // each length at its limits, some with the window short by one
    send_word(in_t'{8'hC2, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd2});
    send_word(in_t'{8'hDF, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1});
    send_word(in_t'{8'hE0, 8'hA0, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3});
    send_word(in_t'{8'hE0, 8'h9F, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3});
    send_word(in_t'{8'hED, 8'h9F, 8'hBF, 8'h00, 8'h00, 8'h00, 3'd3});
    send_word(in_t'{8'hED, 8'hA0, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3});
    send_word(in_t'{8'hEF, 8'hBF, 8'hBF, 8'hFF, 8'hFF, 8'hFF, 3'd7});
    send_word(in_t'{8'hE1, 8'h80, 8'hC0, 8'h00, 8'h00, 8'h00, 3'd3});
    send_word(in_t'{8'hF0, 8'h90, 8'h80, 8'h80, 8'h00, 8'h00, 3'd4});
    send_word(in_t'{8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'h00, 8'h00, 3'd4});
    send_word(in_t'{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 8'h00, 3'd3});
    send_word(in_t'{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5});
    send_word(in_t'{8'hF8, 8'h87, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd5});
    send_word(in_t'{8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hFF, 3'd5});
    send_word(in_t'{8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6});
    send_word(in_t'{8'hFC, 8'h83, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6});
    send_word(in_t'{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7});

    send_idle_pct = 32;
    recv_idle_pct <= 50;
    run_random(300);
    // hold the receiver off while words keep coming, so the block backs up
    hold_requests <= hold_requests + 1;
    run_random(400);

    send_idle_pct = 50;
    recv_idle_pct <= 32;
    run_random(300);
    // drain: offer nothing until every result is back
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    run_random(400);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(600);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d words: 25 directed, %0d well-formed, %0d broken, %0d raw windows",
             words_sent, well_formed, broken, noise);
    $display("Idling went 32/50, 50/32 and 0/0, with one long output stall and one drain");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
